>>> hdl/rpfc_pkg.sv
`timescale 1ns / 1ps

package rpfc_pkg;

  // Pixel word width on both channels
  localparam int PIXEL_W = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_DIRECTION      = 3'd0;
  localparam logic [2:0] CFG_BPP_CODE       = 3'd1;
  localparam logic [2:0] CFG_PACKED_BE      = 3'd2;
  localparam logic [2:0] CFG_CHANNEL_BITS   = 3'd3;
  localparam logic [2:0] CFG_PACKED_SHIFTS  = 3'd4;
  localparam logic [2:0] CFG_WIDE_BE        = 3'd5;
  localparam logic [2:0] CFG_WIDE_LANES     = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  // Packed pixel size codes; the unused code behaves as 32 bits
  localparam logic [1:0] BPP_8  = 2'd0;
  localparam logic [1:0] BPP_16 = 2'd1;
  localparam logic [1:0] BPP_32 = 2'd2;

  // Direction codes
  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  // Reset values of the multi-bit registers
  localparam logic [8:0]  CHANNEL_BITS_RST = 9'd82;
  localparam logic [14:0] SHIFTS_RST       = 15'd6240;
  localparam logic [5:0]  LANES_RST        = 6'd6;

  typedef struct packed {
    logic        direction;
    logic [1:0]  bpp_code;
    logic        packed_be;
    logic [8:0]  channel_bits;
    logic [14:0] shifts;
    logic        wide_be;
    logic [5:0]  lanes;
  } cfg_t;

  // Keep only the bytes of the packed pixel size
  function automatic logic [PIXEL_W-1:0] word_mask(input logic [1:0] bpp);
    case (bpp)
      BPP_8:   word_mask = 32'h0000_00ff;
      BPP_16:  word_mask = 32'h0000_ffff;
      default: word_mask = 32'hffff_ffff;
    endcase
  endfunction

  // Swap byte order within the packed pixel size
  function automatic logic [PIXEL_W-1:0] byte_swap(input logic [PIXEL_W-1:0] w,
                                                   input logic [1:0] bpp);
    case (bpp)
      BPP_8:   byte_swap = w;
      BPP_16:  byte_swap = {16'h0000, w[7:0], w[15:8]};
      default: byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endcase
  endfunction

  // Bit position of an 888 lane in the memory word
  function automatic logic [4:0] lane_pos(input logic [1:0] lane, input logic wide_be);
    logic [1:0] byte_no;
    byte_no  = wide_be ? ~lane : lane;
    lane_pos = {byte_no, 3'b000};
  endfunction

endpackage

>>> hdl/rpfc_pixel_if.sv
`timescale 1ns / 1ps

interface rpfc_pixel_if;
  import rpfc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);

endinterface

>>> hdl/rpfc_chan.sv
`timescale 1ns / 1ps

module rpfc_chan (
  input  logic [7:0] wide_val,
  input  logic [7:0] packed_field,
  input  logic [2:0] width_m1,
  output logic [7:0] packed_val,
  output logic [7:0] wide_out
);
  import rpfc_pkg::*;

  logic [7:0]  maxv;
  logic [15:0] pk_prod;
  logic [16:0] pk_sum;
  logic [16:0] pk_quot;
  logic [7:0]  idx;
  logic [7:0]  rep;
  logic [15:0] rep_prod;
  logic [15:0] idx_255;
  logic [2:0]  ptr;

  // Channel maximum, 2^width - 1
  assign maxv = 8'hff >> (3'd7 - width_m1);

  // Scale down: (v*max + 128) / 255, division by reciprocal for 16-bit values
  assign pk_prod    = wide_val * maxv;
  assign pk_sum     = {1'b0, pk_prod} + 17'd128;
  assign pk_quot    = pk_sum + {8'h00, pk_sum[16:8]} + 17'd1;
  assign packed_val = pk_quot[15:8];

  // Scale up: replicate the index bits, then correct the floor by one
  always_comb begin
    idx = packed_field & maxv;
    ptr = width_m1;
    rep = '0;
    for (int k = 0; k < 8; k++) begin
      rep[7-k] = idx[ptr];
      ptr      = (ptr == 3'd0) ? width_m1 : ptr - 3'd1;
    end
  end

  assign rep_prod = rep * maxv;
  assign idx_255  = {idx, 8'h00} - {8'h00, idx};
  assign wide_out = (rep_prod > idx_255) ? rep - 8'd1 : rep;

endmodule

>>> hdl/rgb_pixel_format_converter.sv
`timescale 1ns / 1ps

// Converts one pixel per transaction between a 32-bit 888 layout and a
// packed true-colour format of 8, 16 or 32 bits (1 to 8 bits per channel).
// Channels: in_chan carries the source pixel bytes, byte 0 in bits 7:0;
// out_chan carries the converted pixel, unused high bytes zero. Both use a
// valid/ready handshake. The cfg port writes one register per cycle when
// cfg_we is high; change it only while no pixel is in flight.
// A pixel passes from the input register through the conversion logic into
// the output register, which drives out_chan.
// Throughput: one pixel per cycle while the receiver does not stall; the
// conversion is a single pass of lane selection, one 8x8 multiply per
// channel per direction and byte swaps.
// Reset (rst_n low, synchronous) empties both stages and loads the default
// format: pack to 8-bit 3:3:2 with red at bit 0.
// When the receiver stalls, the result holds in the output register and one
// more pixel is still taken into the input register; in_chan.ready then
// drops until out_chan.ready returns.
module rgb_pixel_format_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  rpfc_pixel_if.sink                       in_chan,
  rpfc_pixel_if.source                     out_chan,
  input  logic                             cfg_we,
  input  logic [rpfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rpfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rpfc_pkg::*;

  cfg_t               cfg_r;
  logic               s1_v_r;
  logic [PIXEL_W-1:0] s1_pix_r;
  logic               s2_v_r;
  logic [PIXEL_W-1:0] s2_pix_r;
  logic [PIXEL_W-1:0] s2_pix_nxt;
  logic               s1_adv;
  logic               s2_adv;

  logic [PIXEL_W-1:0] mask;
  logic [PIXEL_W-1:0] unp_word;
  logic [7:0]         wide_val   [3];
  logic [7:0]         pk_field   [3];
  logic [7:0]         packed_val [3];
  logic [7:0]         wide_out   [3];
  logic [4:0]         lane_at    [3];
  logic [4:0]         shift_of   [3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction    <= DIR_PACK;
      cfg_r.bpp_code     <= BPP_8;
      cfg_r.packed_be    <= 1'b0;
      cfg_r.channel_bits <= CHANNEL_BITS_RST;
      cfg_r.shifts       <= SHIFTS_RST;
      cfg_r.wide_be      <= 1'b0;
      cfg_r.lanes        <= LANES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION:     cfg_r.direction    <= cfg_data[0];
        CFG_BPP_CODE:      cfg_r.bpp_code     <= cfg_data[1:0];
        CFG_PACKED_BE:     cfg_r.packed_be    <= cfg_data[0];
        CFG_CHANNEL_BITS:  cfg_r.channel_bits <= cfg_data[8:0];
        CFG_PACKED_SHIFTS: cfg_r.shifts       <= cfg_data[14:0];
        CFG_WIDE_BE:       cfg_r.wide_be      <= cfg_data[0];
        CFG_WIDE_LANES:    cfg_r.lanes        <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Handshake: each stage advances when the one after it has room
  assign s2_adv         = !s2_v_r || out_chan.ready;
  assign s1_adv         = !s1_v_r || s2_adv;
  assign in_chan.ready  = s1_adv;
  assign out_chan.valid = s2_v_r;
  assign out_chan.pixel = s2_pix_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_chan.valid) begin
      s1_pix_r <= in_chan.pixel;
    end
  end

  // Unpack source: trim to the packed size and undo its byte order
  assign mask     = word_mask(cfg_r.bpp_code);
  assign unp_word = cfg_r.packed_be ? byte_swap(s1_pix_r & mask, cfg_r.bpp_code)
                                    : (s1_pix_r & mask);

  // Per-channel lane selection and scaling
  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign lane_at[c]  = lane_pos(cfg_r.lanes[2*c +: 2], cfg_r.wide_be);
    assign shift_of[c] = cfg_r.shifts[5*c +: 5];
    assign wide_val[c] = s1_pix_r[lane_at[c] +: 8];
    assign pk_field[c] = unp_word[shift_of[c] +: 8] &
                         ((shift_of[c] > 5'd24) ? (8'hff >> (shift_of[c] - 5'd24))
                                                : 8'hff);

    rpfc_chan u_chan (
      .wide_val     (wide_val[c]),
      .packed_field (pk_field[c]),
      .width_m1     (cfg_r.channel_bits[3*c +: 3]),
      .packed_val   (packed_val[c]),
      .wide_out     (wide_out[c])
    );
  end

  // Assemble the converted pixel
  always_comb begin
    logic [PIXEL_W-1:0] word;
    logic [3:0]         lsum;
    logic [3:0]         pad_lane;
    word     = '0;
    lsum     = 4'd0;
    pad_lane = 4'd0;
    if (cfg_r.direction == DIR_PACK) begin
      for (int c = 0; c < 3; c++) begin
        word = word | ({24'h000000, packed_val[c]} << shift_of[c]);
      end
      word = word & mask;
      if (cfg_r.packed_be) begin
        word = byte_swap(word, cfg_r.bpp_code);
      end
    end else begin
      // Later channels win on colliding lanes; padding byte cleared last
      for (int c = 0; c < 3; c++) begin
        word[lane_at[c] +: 8] = wide_out[c];
        lsum = lsum + {2'b00, cfg_r.lanes[2*c +: 2]};
      end
      pad_lane = 4'd6 - lsum;
      if (lsum >= 4'd3 && lsum <= 4'd6) begin
        word[lane_pos(pad_lane[1:0], cfg_r.wide_be) +: 8] = 8'h00;
      end
    end
    s2_pix_nxt = word;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      s2_pix_r <= s2_pix_nxt;
    end
  end

  // A result only appears after a pixel sat in the input register
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s2_v_r) |-> $past(s1_v_r))
    else $error("result appeared without a pixel in the input register");

  // An empty input register always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_chan.ready)
    else $error("input not ready while input register empty");

  // A blocked input register keeps its pixel
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_adv) |=> (s1_v_r && $stable(s1_pix_r)))
    else $error("input register lost its pixel during a stall");

endmodule
